>>> rtl/cdq_pkg.sv
// Shared types, constants and pointer helpers for the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 32;

    localparam logic [PTR_W-1:0] PTR_ZERO = '0;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [WORD_W-1:0]  data_in;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [WORD_W-1:0]  removed_value;
        logic                      now_empty;
        logic                      now_full;
    } out_beat_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_OUT  = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic capture;   // latch input beat, start element read
        logic execute;   // update pointers/store, load result register
    } ctl_cmd_t;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? PTR_ZERO : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
        return (p == PTR_ZERO) ? PTR_LAST : p - PTR_W'(1);
    endfunction

endpackage

>>> rtl/cdq_ctrl.sv
// Controller state machine: sequences capture, execute and result hand-off.
`timescale 1ns / 1ps
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                state_next = CS_OUT;
            end
            CS_OUT: begin
                if (m_ready) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            CS_EXEC: begin
                cmd.execute = 1'b1;
            end
            CS_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/cdq_datapath.sv
// Datapath: element store, head/tail pointers, empty flag and result register.
`timescale 1ns / 1ps
module cdq_datapath
    import cdq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ctl_cmd_t  cmd,
    input  in_beat_t  s_data,
    output out_beat_t m_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;

    opcode_t           op_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  rd_addr;

    out_beat_t         out_reg, out_next;

    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic              is_push;
    logic              full_cur;

    // Pop front reads at head, everything else at tail (pushes ignore it).
    assign rd_addr = (s_data.opcode == OP_POP_FRONT) ? head_reg : tail_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_data.opcode;
            data_reg    <= s_data.data_in;
            rd_data_reg <= mem[rd_addr];
        end
        if (we) begin
            mem[waddr] <= data_reg;
        end
        if (cmd.execute) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= PTR_ZERO;
            tail_reg  <= PTR_ZERO;
            empty_reg <= 1'b1;
        end else if (cmd.execute) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    assign is_push  = (op_reg == OP_PUSH_REAR) || (op_reg == OP_PUSH_FRONT);
    assign full_cur = !empty_reg && (wrap_next(tail_reg) == head_reg);

    always_comb begin
        head_next              = head_reg;
        tail_next              = tail_reg;
        empty_next             = empty_reg;
        we                     = 1'b0;
        waddr                  = PTR_ZERO;
        out_next.status        = ST_OK;
        out_next.removed_value = '0;
        if (is_push) begin
            if (full_cur) begin
                out_next.status = ST_OVERFLOW;
            end else if (empty_reg) begin
                head_next  = PTR_ZERO;
                tail_next  = PTR_ZERO;
                empty_next = 1'b0;
                we         = cmd.execute;
                waddr      = PTR_ZERO;
            end else if (op_reg == OP_PUSH_REAR) begin
                tail_next = wrap_next(tail_reg);
                we        = cmd.execute;
                waddr     = tail_next;
            end else begin
                head_next = wrap_prev(head_reg);
                we        = cmd.execute;
                waddr     = head_next;
            end
        end else begin
            if (empty_reg) begin
                out_next.status = ST_UNDERFLOW;
            end else begin
                out_next.removed_value = rd_data_reg;
                if (head_reg == tail_reg) begin
                    head_next  = PTR_ZERO;
                    tail_next  = PTR_ZERO;
                    empty_next = 1'b1;
                end else if (op_reg == OP_POP_FRONT) begin
                    head_next = wrap_next(head_reg);
                end else begin
                    tail_next = wrap_prev(tail_reg);
                end
            end
        end
        out_next.now_empty = empty_next;
        out_next.now_full  = !empty_next && (wrap_next(tail_next) == head_next);
    end

    assign m_data = out_reg;

endmodule

>>> rtl/circular_deque.sv
// Top level of the circular deque: controller plus datapath.
// Sequence: an accepted s_ beat is captured together with the element-store
//   read, then executed, then offered as a result beat with m_valid; the store
//   read is registered ahead of the execute step, and a new s_ beat is taken
//   only after m_ready has taken the result beat.
// Reset: aresetn is synchronous, active low; it empties the deque (head and
//   tail to zero) and drops m_valid. Store contents are not cleared.
`timescale 1ns / 1ps
module circular_deque
    import cdq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    // input beats: opcode and data word
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    // result beats: status, popped word, empty/full after the operation
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // Command bundle from controller to datapath.
    ctl_cmd_t cmd;

    // Controller owns both handshakes; one operation is in flight at a time,
    // so the datapath never sees a new beat while a result is pending.
    cdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath holds the store, the pointers and the result register,
    // which stays stable while m_valid waits for m_ready.
    cdq_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

>>> rtl/cdq_checker.sv
// Port-level checker for the circular deque, bound to the top level.
`timescale 1ns / 1ps
module cdq_checker
    import cdq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // A pending result beat holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Only one operation in flight: no input accepted while a result waits.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("input accepted while result pending");

    // Failed operations return no word.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.removed_value == '0)
        else $error("nonzero word on failed operation");

    // Overflow only ever comes from a full deque, and it stays full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_OVERFLOW) |-> m_data.now_full)
        else $error("overflow reported on non-full deque");

    // Empty and full are exclusive for any depth of two or more.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.now_empty && m_data.now_full))
        else $error("deque reported both empty and full");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> test/testbench.sv
// Self-checking testbench for circular_deque: predicts every result beat and compares it.
`timescale 1ns / 1ps
module testbench;
    import cdq_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_OPS    = 750;
    localparam int DRAIN_CYCLES  = 12;
    localparam int REPORT_LIMIT  = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    circular_deque i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow deque: own copy of pointers, empty flag and word store
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]  shadow_front = PTR_ZERO;
    logic [PTR_W-1:0]  shadow_rear  = PTR_ZERO;
    bit                shadow_empty = 1'b1;
    logic [WORD_W-1:0] shadow_words [DEPTH];

    in_beat_t  pending_ops[$];       // beats waiting for the driver
    out_beat_t expected_results[$];  // predicted result beats, oldest first

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    bit  beat_taken     = 1'b0;
    int  burst_left     = 1;
    int  gap_left       = 0;
    int  ready_mode     = 0;
    int  ready_hold     = 0;
    int  ready_tick     = 0;

    function automatic logic [PTR_W-1:0] ptr_up(input logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? PTR_ZERO : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
        return (p == PTR_ZERO) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    function automatic bit shadow_full();
        return !shadow_empty && (ptr_up(shadow_rear) == shadow_front);
    endfunction

    // Applies one operation to the shadow deque and returns the result beat.
    function automatic out_beat_t apply_deque_op(input in_beat_t beat);
        out_beat_t res;
        res = '0;
        res.status = ST_OK;
        case (beat.opcode)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (shadow_full()) begin
                    res.status = ST_OVERFLOW;
                end else if (shadow_empty) begin
                    // first element always lands in slot zero
                    shadow_front    = PTR_ZERO;
                    shadow_rear     = PTR_ZERO;
                    shadow_words[0] = beat.data_in;
                    shadow_empty    = 1'b0;
                end else if (beat.opcode == OP_PUSH_REAR) begin
                    shadow_rear               = ptr_up(shadow_rear);
                    shadow_words[shadow_rear] = beat.data_in;
                end else begin
                    shadow_front               = ptr_down(shadow_front);
                    shadow_words[shadow_front] = beat.data_in;
                end
            end
            default: begin
                if (shadow_empty) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.removed_value = (beat.opcode == OP_POP_FRONT) ?
                        shadow_words[shadow_front] : shadow_words[shadow_rear];
                    if (shadow_front == shadow_rear) begin
                        // last element gone: back to the reset layout
                        shadow_front = PTR_ZERO;
                        shadow_rear  = PTR_ZERO;
                        shadow_empty = 1'b1;
                    end else if (beat.opcode == OP_POP_FRONT) begin
                        shadow_front = ptr_up(shadow_front);
                    end else begin
                        shadow_rear = ptr_down(shadow_rear);
                    end
                end
            end
        endcase
        res.now_empty = shadow_empty;
        res.now_full  = shadow_full();
        return res;
    endfunction

    task automatic queue_op(input opcode_t op, input logic [WORD_W-1:0] word);
        in_beat_t beat;
        beat.opcode  = op;
        beat.data_in = word;
        pending_ops.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps, changes at falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || beat_taken)) begin
            if (gap_left > 0 || pending_ops.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending_ops.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: switches between stall patterns every so often
    always @(negedge aclk) begin
        ready_tick++;
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(20, 150);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (ready_tick % 5 == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Prediction on accepted input beats, checking on result beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end else begin
            beat_taken = aresetn && s_valid && s_ready;
            if (beat_taken)
                expected_results.push_back(apply_deque_op(s_data));

            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result beat: %p", m_data);
                    mismatch_count++;
                end else begin
                    out_beat_t exp_beat;
                    exp_beat = expected_results.pop_front();
                    if (m_data.status !== exp_beat.status ||
                        m_data.removed_value !== exp_beat.removed_value ||
                        m_data.now_empty !== exp_beat.now_empty ||
                        m_data.now_full !== exp_beat.now_full) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("mismatch: expected %p, got %p", exp_beat, m_data);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int          push_pct;
        int          seg_left;
        opcode_t     op;
        logic [31:0] word;

        // underflow on both ends of an empty deque
        queue_op(OP_POP_FRONT, 32'h0000_0000);
        queue_op(OP_POP_REAR,  32'hFFFF_FFFF);
        // single element in and out again
        queue_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
        queue_op(OP_POP_FRONT, 32'h1234_5678);
        // fill to full, alternating ends so the front pointer wraps
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 6)
                0: word = 32'h8000_0000;
                1: word = 32'hFFFF_FFFF;
                2: word = 32'h0000_0000;
                3: word = 32'h7FFF_FFFF;
                4: word = 32'hAAAA_AAAA;
                default: word = 32'h5555_5555;
            endcase
            queue_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, word);
        end
        // overflow on both ends, then pops from both ends
        queue_op(OP_PUSH_REAR,  32'h0000_0001);
        queue_op(OP_PUSH_FRONT, 32'hFFFF_FFFE);
        queue_op(OP_POP_FRONT,  32'h0000_0000);
        queue_op(OP_POP_REAR,   32'h0000_0000);

        // random part: segments biased toward filling, draining or balance
        seg_left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = ($urandom_range(0, 1) == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
            case ($urandom_range(0, 7))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0000_0000;
                3:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            queue_op(op, word);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque.sv
rtl/cdq_checker.sv
test/testbench.sv
